### hw/rtl/slc_pkg.sv
// shared types and constants for the sharded lru cache
// used by slc_ways and sharded_lru_cache; no dependencies
package slc_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CFG_BITS   = 4;

    localparam logic [CFG_BITS-1:0] WAYS_IN_USE_RESET = 4'd8;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // lookup result handed from the way logic to the sequencer
    typedef struct packed {
        logic hit;
        logic wrote;
    } status_t;

endpackage

### hw/rtl/sharded_lru_cache.sv
// sharded lru key-value cache top level: sequencer, config register, response register
// uses slc_pkg, slc_ram, slc_shard, slc_ways
//
// channel   signals                              direction   beat
// cfg       cfg_valid cfg_ready ways_in_use      in          capacity per shard
// req       req_valid req_stall func key ...     in          get or set request
// rsp       rsp_valid rsp_stall hit read_value   out         one result per request
//
// one request at a time: accept, shard reduction, row read, row write-back
// the steps are set by the key-modulo pipeline and the single row memory port pair
// after reset a clearing pass zeroes every row; req_stall stays high
// a stalled response holds the write-back until the response register frees up
module sharded_lru_cache #(
    parameter int SHARDS    = 8,
    parameter int WAYS      = 8,
    parameter int DATA_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slc_pkg::CFG_BITS-1:0]       ways_in_use,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               func,
    input  logic signed [slc_pkg::KEY_BITS-1:0]   key,
    input  logic signed [slc_pkg::VALUE_BITS-1:0] write_value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               hit,
    output logic signed [slc_pkg::VALUE_BITS-1:0] read_value
);

    localparam int SHARD_BITS = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam int AGE_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_BITS = 1 + AGE_BITS + slc_pkg::KEY_BITS + DATA_BITS;
    localparam int ROW_BITS   = WAYS * ENTRY_BITS;

    slc_pkg::state_t state_reg;
    slc_pkg::state_t state_next;
    logic [SHARD_BITS-1:0] clr_cnt_reg;
    logic [SHARD_BITS-1:0] clr_cnt_next;
    logic [slc_pkg::CFG_BITS-1:0] ways_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    logic                           func_reg;
    logic [slc_pkg::KEY_BITS-1:0]   key_reg;
    logic [slc_pkg::VALUE_BITS-1:0] wval_reg;
    logic [SHARD_BITS-1:0]          shard_reg;
    logic                           hit_reg;
    logic [slc_pkg::VALUE_BITS-1:0] rdval_reg;

    logic                  req_fire;
    logic                  out_free;
    logic                  upd_done;
    logic [SHARD_BITS-1:0] shard_idx;
    logic                  ram_we;
    logic                  ram_re;
    logic [SHARD_BITS-1:0] ram_waddr;
    logic [ROW_BITS-1:0]   ram_wdata;
    logic [ROW_BITS-1:0]   ram_rdata;
    logic [ROW_BITS-1:0]   row_next;
    logic [DATA_BITS-1:0]  rd_value;
    slc_pkg::status_t      status;

    assign cfg_ready = 1'b1;
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    slc_shard #(
        .SHARDS(SHARDS)
    ) u_shard (
        .clk   (clk),
        .load  (req_fire),
        .key   (key),
        .shard (shard_idx)
    );

    slc_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(SHARDS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (shard_idx),
        .rdata (ram_rdata)
    );

    slc_ways #(
        .WAYS      (WAYS),
        .DATA_BITS (DATA_BITS)
    ) u_ways (
        .row         (ram_rdata),
        .func        (func_reg),
        .key         (key_reg),
        .wval        (DATA_BITS'(wval_reg)),
        .ways_in_use (ways_reg),
        .status      (status),
        .row_next    (row_next),
        .rd_value    (rd_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall      = 1'b1;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = shard_reg;
        ram_wdata      = row_next;
        upd_done       = 1'b0;
        case (state_reg)
            slc_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SHARD_BITS'(SHARDS - 1))
                begin
                    state_next = slc_pkg::ST_IDLE;
                end
            end
            slc_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = slc_pkg::ST_REDUCE;
                end
            end
            slc_pkg::ST_REDUCE:
            begin
                state_next = slc_pkg::ST_LOOKUP;
            end
            slc_pkg::ST_LOOKUP:
            begin
                ram_re     = 1'b1;
                state_next = slc_pkg::ST_UPDATE;
            end
            slc_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    upd_done       = 1'b1;
                    ram_we         = status.wrote;
                    rsp_valid_next = 1'b1;
                    state_next     = slc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            ways_reg      <= slc_pkg::WAYS_IN_USE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                ways_reg <= ways_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg <= func;
            key_reg  <= key;
            wval_reg <= write_value;
        end
        if (state_reg == slc_pkg::ST_LOOKUP)
        begin
            shard_reg <= shard_idx;
        end
        if (upd_done)
        begin
            hit_reg   <= status.hit;
            rdval_reg <= slc_pkg::VALUE_BITS'(rd_value);
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign hit        = hit_reg;
    assign read_value = rdval_reg;

    // an accepted request always enters the shard reduction next
    a_accept_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == slc_pkg::ST_REDUCE)
        else $error("accepted request did not enter reduction");

    // the row memory is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("row memory read and write overlap");

    // a response only appears out of the write-back state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == slc_pkg::ST_UPDATE)
        else $error("response raised outside write-back");

    // a new response is never loaded over one that is still stalled
    a_rsp_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stall |-> !upd_done)
        else $error("response overwritten while stalled");

endmodule

### hw/rtl/slc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module slc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

### hw/rtl/slc_shard.sv
// shard index unit: unsigned 32-bit key modulo SHARDS in two register stages
// byte-weighted sum, then restoring reduction split across the two register stages
module slc_shard #(
    parameter int SHARDS = 8
) (
    input  logic                                          clk,
    input  logic                                          load,
    input  logic [31:0]                                   key,
    output logic [((SHARDS > 1) ? $clog2(SHARDS) : 1)-1:0] shard
);

    localparam int SHARD_BITS = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam int W0 = 1 % SHARDS;
    localparam int W1 = 256 % SHARDS;
    localparam int W2 = 65536 % SHARDS;
    localparam int W3 = 16777216 % SHARDS;

    logic [15:0] sum_reg;
    logic [15:0] part_reg;
    logic [15:0] sum_next;
    logic [15:0] part_next;
    logic [15:0] rem;

    // each byte times its weight 256^i mod SHARDS
    assign sum_next = 16'(key[7:0])   * 16'(W0) + 16'(key[15:8])  * 16'(W1)
                    + 16'(key[23:16]) * 16'(W2) + 16'(key[31:24]) * 16'(W3);

    always_comb
    begin
        part_next = sum_reg;
        for (int j = 15; j >= 8; j--)
        begin
            if ({7'd0, part_next} >= (23'(SHARDS) << j))
            begin
                part_next = part_next - 16'(23'(SHARDS) << j);
            end
        end
    end

    always_comb
    begin
        rem = part_reg;
        for (int j = 7; j >= 0; j--)
        begin
            if ({7'd0, rem} >= (23'(SHARDS) << j))
            begin
                rem = rem - 16'(23'(SHARDS) << j);
            end
        end
    end

    assign shard = SHARD_BITS'(rem);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
        part_reg <= part_next;
    end

endmodule

### hw/rtl/slc_ways.sv
// way logic: hit search, victim and free way choice, age update of one shard row
// uses slc_pkg for the status struct and operation codes
module slc_ways #(
    parameter int WAYS      = 8,
    parameter int DATA_BITS = 32
) (
    input  logic [WAYS*(1+((WAYS > 1) ? $clog2(WAYS) : 1)+32+DATA_BITS)-1:0] row,
    input  logic                                  func,
    input  logic [31:0]                           key,
    input  logic [DATA_BITS-1:0]                  wval,
    input  logic [slc_pkg::CFG_BITS-1:0]          ways_in_use,
    output slc_pkg::status_t                      status,
    output logic [WAYS*(1+((WAYS > 1) ? $clog2(WAYS) : 1)+32+DATA_BITS)-1:0] row_next,
    output logic [DATA_BITS-1:0]                  rd_value
);

    localparam int AGE_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_BITS   = $clog2(WAYS + 1);
    localparam int KEY_BITS   = slc_pkg::KEY_BITS;
    localparam int ENTRY_BITS = 1 + AGE_BITS + KEY_BITS + DATA_BITS;

    logic [WAYS-1:0]      valid_a;
    logic [AGE_BITS-1:0]  age_a [WAYS];
    logic [KEY_BITS-1:0]  key_a [WAYS];
    logic [DATA_BITS-1:0] val_a [WAYS];
    logic [WAYS-1:0]      valid_n;
    logic [AGE_BITS-1:0]  age_n [WAYS];
    logic [KEY_BITS-1:0]  key_n [WAYS];
    logic [DATA_BITS-1:0] val_n [WAYS];

    logic [WAYS-1:0]     match;
    logic [WAYS-1:0]     free;
    logic [WAYS-1:0]     oldest;
    logic [CNT_BITS-1:0] count;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] free_way;
    logic [WAY_BITS-1:0] vict_way;
    logic [WAY_BITS-1:0] ins_way;
    logic [AGE_BITS-1:0] hit_age;
    logic [6:0]          cap;
    logic                found;
    logic                room;
    logic                do_insert;

    always_comb
    begin
        count = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            valid_a[i] = row[i*ENTRY_BITS + ENTRY_BITS - 1];
            age_a[i]   = row[i*ENTRY_BITS + KEY_BITS + DATA_BITS +: AGE_BITS];
            key_a[i]   = row[i*ENTRY_BITS + DATA_BITS +: KEY_BITS];
            val_a[i]   = row[i*ENTRY_BITS +: DATA_BITS];
            count      = count + CNT_BITS'(valid_a[i]);
        end
    end

    // ages of valid entries are always 0..count-1, so the oldest has count-1
    always_comb
    begin
        hit_way  = '0;
        free_way = '0;
        vict_way = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            match[i]  = valid_a[i] && (key_a[i] == key);
            free[i]   = !valid_a[i];
            oldest[i] = valid_a[i] && (CNT_BITS'(age_a[i]) == count - CNT_BITS'(1));
        end
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_way = WAY_BITS'(i);
            end
            if (free[i])
            begin
                free_way = WAY_BITS'(i);
            end
            if (oldest[i])
            begin
                vict_way = WAY_BITS'(i);
            end
        end
    end

    assign found     = |match;
    assign hit_age   = age_a[hit_way];
    assign cap       = ({3'd0, ways_in_use} > 7'(WAYS)) ? 7'(WAYS) : {3'd0, ways_in_use};
    assign room      = (7'(count) < cap) && (|free);
    assign do_insert = !found && (func == slc_pkg::FUNC_SET) && (cap != 7'd0)
                     && (room || (|oldest));
    assign ins_way   = room ? free_way : vict_way;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            valid_n[i] = valid_a[i];
            age_n[i]   = age_a[i];
            key_n[i]   = key_a[i];
            val_n[i]   = val_a[i];
            if (found)
            begin
                if (valid_a[i] && (WAY_BITS'(i) != hit_way) && (age_a[i] < hit_age))
                begin
                    age_n[i] = age_a[i] + 1'b1;
                end
            end
            else if (do_insert)
            begin
                if (valid_a[i] && (WAY_BITS'(i) != ins_way))
                begin
                    age_n[i] = age_a[i] + 1'b1;
                end
            end
        end
        if (found)
        begin
            age_n[hit_way] = '0;
            if (func == slc_pkg::FUNC_SET)
            begin
                val_n[hit_way] = wval;
            end
        end
        else if (do_insert)
        begin
            valid_n[ins_way] = 1'b1;
            age_n[ins_way]   = '0;
            key_n[ins_way]   = key;
            val_n[ins_way]   = wval;
        end
        for (int i = 0; i < WAYS; i++)
        begin
            row_next[i*ENTRY_BITS +: ENTRY_BITS] = {valid_n[i], age_n[i], key_n[i], val_n[i]};
        end
    end

    assign rd_value     = (found && (func == slc_pkg::FUNC_GET)) ? val_a[hit_way] : '0;
    assign status.hit   = found;
    assign status.wrote = found || do_insert;

endmodule

### tb/sharded_lru_cache_tb.sv
// self-checking testbench for sharded_lru_cache: directed and random get/set traffic,
// predicted by a shadow copy of every shard and its recency ages, checked beat by beat
// depends on slc_pkg and the sharded_lru_cache rtl
`timescale 1ns / 1ps

module sharded_lru_cache_tb;

    localparam int SHARDS = 8;
    localparam int WAYS   = 8;

    typedef struct {
        logic        op;
        logic [31:0] k;
        logic [31:0] v;
    } cache_req_t;

    typedef struct {
        logic        hit;
        logic [31:0] value;
    } lookup_result_t;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [slc_pkg::CFG_BITS-1:0] ways_in_use = slc_pkg::WAYS_IN_USE_RESET;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    logic                         func = slc_pkg::FUNC_GET;
    logic signed [31:0]           key = '0;
    logic signed [31:0]           write_value = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    logic                         hit;
    logic signed [31:0]           read_value;

    // shadow of the cache contents
    logic [31:0]                  way_key   [SHARDS][WAYS];
    logic [31:0]                  way_value [SHARDS][WAYS];
    bit                           way_valid [SHARDS][WAYS];
    bit [2:0]                     way_age   [SHARDS][WAYS];
    logic [slc_pkg::CFG_BITS-1:0] ways_cap = slc_pkg::WAYS_IN_USE_RESET;

    cache_req_t            pending_reqs [$];
    lookup_result_t        expected_results [$];

    int                    items_accepted = 0;
    int                    mismatch_count = 0;
    bit                    sender_idle_on = 1'b0;
    bit                    receiver_idle_on = 1'b0;
    int                    send_gap = 0;
    int                    rsp_gap = 0;
    int                    hold_left = 0;
    int                    next_hold_at = 150;
    logic                  next_valid;
    cache_req_t            next_req;
    lookup_result_t        want;

    sharded_lru_cache #(
        .SHARDS    (SHARDS),
        .WAYS      (WAYS),
        .DATA_BITS (32)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .ways_in_use (ways_in_use),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .key         (key),
        .write_value (write_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .hit         (hit),
        .read_value  (read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void make_recent(input int sh, input int w, input int limit);
        for (int i = 0; i < WAYS; i++)
        begin
            if (i != w && way_valid[sh][i] && way_age[sh][i] < limit)
                way_age[sh][i] = way_age[sh][i] + 3'd1;
        end
        way_age[sh][w] = '0;
    endfunction

    function automatic lookup_result_t cache_access(input logic op, input logic [31:0] k,
                                                    input logic [31:0] v);
        lookup_result_t res;
        int sh, cap, count, found, free_way, victim, oldest, w, limit;
        sh       = int'(k % SHARDS);
        cap      = (ways_cap > WAYS) ? WAYS : int'(ways_cap);
        count    = 0;
        found    = WAYS;
        free_way = WAYS;
        victim   = WAYS;
        oldest   = 0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (way_valid[sh][i])
            begin
                count++;
                if (way_key[sh][i] == k)
                    found = i;
                if (victim == WAYS || way_age[sh][i] > oldest)
                begin
                    victim = i;
                    oldest = way_age[sh][i];
                end
            end
            else if (free_way == WAYS)
            begin
                free_way = i;
            end
        end
        res.hit   = 1'b0;
        res.value = '0;
        if (found < WAYS)
        begin
            res.hit = 1'b1;
            if (op == slc_pkg::FUNC_GET)
                res.value = way_value[sh][found];
            else
                way_value[sh][found] = v;
            make_recent(sh, found, way_age[sh][found]);
        end
        else if (op == slc_pkg::FUNC_SET && cap > 0)
        begin
            if (count < cap && free_way < WAYS)
            begin
                w     = free_way;
                limit = WAYS;
            end
            else
            begin
                w     = victim;
                limit = oldest;
            end
            if (w < WAYS)
            begin
                make_recent(sh, w, limit);
                way_valid[sh][w] = 1'b1;
                way_key[sh][w]   = k;
                way_value[sh][w] = v;
            end
        end
        return res;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            func        <= slc_pkg::FUNC_GET;
            key         <= '0;
            write_value <= '0;
            send_gap = 0;
        end
        else
        begin
            next_valid = req_valid;
            if (req_valid && !req_stall)
            begin
                expected_results.push_back(cache_access(func, key, write_value));
                items_accepted <= items_accepted + 1;
                next_valid = 1'b0;
                send_gap = sender_idle_on ? $urandom_range(0, 19) : 0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    func        <= next_req.op;
                    key         <= next_req.k;
                    write_value <= next_req.v;
                    next_valid = 1'b1;
                end
            end
            req_valid <= next_valid;
        end
    end

    // long response hold-off so the request side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            next_hold_at <= 150;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (items_accepted >= next_hold_at && next_hold_at < 600)
        begin
            hold_left    <= 160;
            next_hold_at <= next_hold_at + 250;
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_gap = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected beat: hit %0b read_value %h", $time, hit,
                             read_value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (hit !== want.hit)
                    begin
                        $display("%0t: hit mismatch: expected %0b actual %0b", $time,
                                 want.hit, hit);
                        mismatch_count++;
                    end
                    if (read_value !== want.value)
                    begin
                        $display("%0t: read_value mismatch: expected %h actual %h", $time,
                                 want.value, read_value);
                        mismatch_count++;
                    end
                end
                rsp_gap = receiver_idle_on ? $urandom_range(0, 19) : 0;
            end
            if (hold_left != 0)
            begin
                rsp_stall <= 1'b1;
            end
            else if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic push_req(input logic op, input logic [31:0] k, input logic [31:0] v);
        cache_req_t r;
        r.op = op;
        r.k  = k;
        r.v  = v;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_ways(input logic [slc_pkg::CFG_BITS-1:0] v);
        @(posedge clk);
        cfg_valid   <= 1'b1;
        ways_in_use <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ways_cap = v;
    endtask

    task automatic add_random_phase(input int n);
        logic [31:0] pool [$];
        logic [31:0] k, v;
        int span, first_shard, pick;
        span        = 1 << $urandom_range(0, 3);
        first_shard = $urandom_range(0, SHARDS - 1);
        // small key pool on 1, 2, 4 or 8 adjacent shards so hits and evictions are frequent
        repeat ($urandom_range(6, 24))
        begin
            k = $urandom;
            k = (k / SHARDS) * SHARDS + (first_shard + $urandom_range(0, span - 1)) % SHARDS;
            pool.push_back(k);
        end
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                k = pool[$urandom_range(0, pool.size() - 1)];
            else
                k = $urandom;
            case ($urandom_range(0, 7))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h0000_0000;
                3: v = 32'hffff_ffff;
                default: v = $urandom;
            endcase
            push_req($urandom_range(0, 1) ? slc_pkg::FUNC_SET : slc_pkg::FUNC_GET, k, v);
        end
    endtask

    initial
    begin
        logic [slc_pkg::CFG_BITS-1:0] phase_caps [9];
        phase_caps = '{4'd2, 4'd0, 4'd1, 4'd15, 4'd4, 4'd9, 4'd3, 4'd8, 4'd5};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes, hits, misses, set hit, fill and evict shard 0
        push_req(slc_pkg::FUNC_SET, 32'h0000_0000, 32'h7fff_ffff);
        push_req(slc_pkg::FUNC_SET, 32'hffff_ffff, 32'h8000_0000);
        push_req(slc_pkg::FUNC_SET, 32'h7fff_ffff, 32'hffff_ffff);
        push_req(slc_pkg::FUNC_SET, 32'h8000_0000, 32'h0000_0000);
        push_req(slc_pkg::FUNC_GET, 32'hffff_ffff, 32'h0000_0000);
        push_req(slc_pkg::FUNC_GET, 32'h7fff_ffff, 32'h0000_0000);
        push_req(slc_pkg::FUNC_GET, 32'h8000_0000, 32'hffff_ffff);
        push_req(slc_pkg::FUNC_GET, 32'h0000_0008, 32'hdead_beef);
        push_req(slc_pkg::FUNC_SET, 32'h0000_0000, 32'h1234_5678);
        push_req(slc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        for (int i = 1; i <= 7; i++)
            push_req(slc_pkg::FUNC_SET, 32'(i * SHARDS), 32'(i * 32'h0101_0101));
        push_req(slc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        push_req(slc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        push_req(slc_pkg::FUNC_GET, 32'h0000_0038, 32'h0000_0000);
        wait_idle();

        foreach (phase_caps[p])
        begin
            write_ways(phase_caps[p]);
            @(negedge clk);
            sender_idle_on   = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            receiver_idle_on = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            add_random_phase(65);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("sharded_lru_cache regression: pass");
        else
            $display("sharded_lru_cache regression: fail");
        $finish;
    end

    initial
    begin
        #3_200_000;
        $display("sharded_lru_cache regression: fail");
        $finish;
    end

endmodule
